@@ sv/ils_pkg.sv @@
// Shared types, codes and constants of the indexed list store.
package ils_pkg;

	// Field widths of the command and response words.
	localparam int OPC_W     = 3;
	localparam int POS_W     = 7;
	localparam int DATA_W    = 32;
	localparam int STS_W     = 2;
	localparam int CNT_OUT_W = 7;

	// Default number of entries the store can hold.
	localparam int CAPACITY_DEF = 64;

	// Command opcodes.
	localparam logic [OPC_W-1:0] OP_READ = 3'd0;
	localparam logic [OPC_W-1:0] OP_HEAD = 3'd1;
	localparam logic [OPC_W-1:0] OP_TAIL = 3'd2;
	localparam logic [OPC_W-1:0] OP_AT   = 3'd3;
	localparam logic [OPC_W-1:0] OP_DEL  = 3'd4;

	// Response status codes.
	localparam logic [STS_W-1:0] STS_DONE  = 2'd0;
	localparam logic [STS_W-1:0] STS_RANGE = 2'd1;
	localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

	// Read value returned when nothing was read.
	localparam logic signed [DATA_W-1:0] NEG_ONE = -32'sd1;

	// Command word.
	typedef struct packed {
		logic [OPC_W-1:0]         opcode;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

	// Response word.
	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic [STS_W-1:0]         status;
		logic [CNT_OUT_W-1:0]     entry_count;
	} rsp_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;    // capture the accepted command word
		logic start;   // decode the command and set up the shift
		logic step;    // move one entry per cycle
		logic commit;  // final write, count update, response capture
	} ctl_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic shift_done;
	} dp_sts_t;

endpackage

@@ sv/indexed_list_store.sv @@
// Top level of the indexed list store: controller, datapath and entry RAM.
//
//   channel   handshake               word    direction
//   cmd       cmd_valid / cmd_stall   cmd_t   into the block
//   rsp       rsp_valid / rsp_stall   rsp_t   out of the block
//
// One command word is worked at a time. A read, a refused command, an unused
// opcode, or an insert or delete that moves no entry goes through the decode,
// shift and commit states to the response register; an insert or delete that
// moves entries stays in the shift state until it has moved (up to CAPACITY-1), since the shift
// moves one entry a cycle through the single RAM write port. The next word is
// taken in the idle state that follows the commit.
// Reset clears the count; RAM contents are not cleared and need no sweep.
// A stalled response holds in its register while the next word is accepted.
module indexed_list_store import ils_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	ctl_cmd_t ctl;
	dp_sts_t  sts;

	ils_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.ctl       (ctl),
		.sts       (sts)
	);

	ils_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.ctl    (ctl),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

@@ sv/ils_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module ils_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read; read data holds when no read is issued.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/ils_ctrl.sv @@
// Controller state machine that sequences each command word through the datapath.
module ils_ctrl import ils_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_stall,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output ctl_cmd_t ctl,
	input  dp_sts_t  sts
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_DECODE = 2'd1;
	localparam logic [1:0] S_SHIFT  = 2'd2;
	localparam logic [1:0] S_COMMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nx;
	logic       rsp_valid_q;
	logic       slot_free;

	// The response register can take a new word when empty or being drained.
	assign slot_free = !rsp_valid_q || !rsp_stall;

	// Commands to the datapath.
	always_comb begin
		ctl.load   = (state_q == S_IDLE) && cmd_valid;
		ctl.start  = (state_q == S_DECODE);
		ctl.step   = (state_q == S_SHIFT);
		ctl.commit = (state_q == S_COMMIT) && slot_free;
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					state_nx = S_DECODE;
				end
			end
			S_DECODE: begin
				state_nx = S_SHIFT;
			end
			S_SHIFT: begin
				if (sts.shift_done) begin
					state_nx = S_COMMIT;
				end
			end
			S_COMMIT: begin
				if (slot_free) begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// State and response valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (ctl.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign cmd_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

endmodule

@@ sv/ils_dp.sv @@
// Datapath: entry RAM, entry count, shift sequencing and the response register.
module ils_dp import ils_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cmd_t     cmd,
	input  ctl_cmd_t ctl,
	output dp_sts_t  sts,
	output rsp_t     rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	cmd_t             cmd_q;
	rsp_t             rsp_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    rem_q;
	logic [AW-1:0]    src_q;
	logic [AW-1:0]    dst_s1;
	logic             mv_s1;

	logic [PW-1:0]    pos_w;
	logic [PW-1:0]    cnt_w;
	logic             full;
	logic             do_read;
	logic             do_ins;
	logic             do_del;
	logic [STS_W-1:0] sts_code;
	logic [AW-1:0]    tgt;
	logic [CW-1:0]    cnt_nx;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	// Decode the held command against the current count.
	always_comb begin
		pos_w    = PW'(cmd_q.position);
		cnt_w    = PW'(count_q);
		full     = (count_q == CW'(CAPACITY));
		do_read  = 1'b0;
		do_ins   = 1'b0;
		do_del   = 1'b0;
		sts_code = STS_DONE;
		tgt      = '0;
		unique case (cmd_q.opcode)
			OP_READ: begin
				if (pos_w < cnt_w) begin
					do_read = 1'b1;
					tgt     = AW'(pos_w);
				end else begin
					sts_code = STS_RANGE;
				end
			end
			OP_HEAD: begin
				if (full) begin
					sts_code = STS_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			OP_TAIL: begin
				if (full) begin
					sts_code = STS_FULL;
				end else begin
					do_ins = 1'b1;
					tgt    = AW'(count_q);
				end
			end
			OP_AT: begin
				if (pos_w > cnt_w) begin
					sts_code = STS_RANGE;
				end else if (full) begin
					sts_code = STS_FULL;
				end else begin
					do_ins = 1'b1;
					tgt    = AW'(pos_w);
				end
			end
			OP_DEL: begin
				if (pos_w >= cnt_w) begin
					sts_code = STS_RANGE;
				end else begin
					do_del = 1'b1;
					tgt    = AW'(pos_w);
				end
			end
			default: begin
				sts_code = STS_DONE;
			end
		endcase
	end

	// Count after the command completes.
	always_comb begin
		if (do_ins) begin
			cnt_nx = count_q + CW'(1);
		end else if (do_del) begin
			cnt_nx = count_q - CW'(1);
		end else begin
			cnt_nx = count_q;
		end
	end

	// RAM ports: a shift reads one entry and writes the one read in the step before;
	// the commit writes the new value of an insert.
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = src_q;
		if (ctl.start && do_read) begin
			ram_re    = 1'b1;
			ram_raddr = tgt;
		end else if (ctl.step && (rem_q != '0)) begin
			ram_re    = 1'b1;
			ram_raddr = src_q;
		end
		ram_we    = 1'b0;
		ram_waddr = dst_s1;
		ram_wdata = ram_rdata;
		if (ctl.step && mv_s1) begin
			ram_we = 1'b1;
		end else if (ctl.commit && do_ins) begin
			ram_we    = 1'b1;
			ram_waddr = tgt;
			ram_wdata = cmd_q.value;
		end
	end

	assign sts.shift_done = (rem_q == '0) && !mv_s1;

	// Command word capture.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd;
		end
	end

	// Shift addresses: an insert walks down from the last entry, a delete walks up.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			if (do_ins) begin
				src_q <= AW'(count_q - CW'(1));
			end else begin
				src_q <= tgt + AW'(1);
			end
		end else if (ctl.step && (rem_q != '0)) begin
			if (do_ins) begin
				src_q  <= src_q - AW'(1);
				dst_s1 <= src_q + AW'(1);
			end else begin
				src_q  <= src_q + AW'(1);
				dst_s1 <= src_q - AW'(1);
			end
		end
	end

	// Move counter, move-in-flight flag and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rem_q   <= '0;
			mv_s1   <= 1'b0;
		end else begin
			if (ctl.start) begin
				mv_s1 <= 1'b0;
				if (do_ins) begin
					rem_q <= count_q - CW'(tgt);
				end else if (do_del) begin
					rem_q <= count_q - CW'(tgt) - CW'(1);
				end else begin
					rem_q <= '0;
				end
			end else if (ctl.step) begin
				if (rem_q != '0) begin
					rem_q <= rem_q - CW'(1);
					mv_s1 <= 1'b1;
				end else begin
					mv_s1 <= 1'b0;
				end
			end
			if (ctl.commit) begin
				count_q <= cnt_nx;
			end
		end
	end

	// Response word capture.
	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			rsp_q.read_value  <= do_read ? ram_rdata : NEG_ONE;
			rsp_q.status      <= sts_code;
			rsp_q.entry_count <= CNT_OUT_W'(PW'(cnt_nx));
		end
	end

	assign rsp = rsp_q;

	ils_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

@@ sv/ils_chk.sv @@
// Port-level checker for the indexed list store and its bind to the top level.
module ils_chk import ils_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_stall,
	input cmd_t cmd,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// A stalled response word stays valid and unchanged.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response word changed while stalled");

	// The block works one word at a time, so an accepted word stalls the next.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("command accepted while the previous one is still in work");

	// Only defined status codes appear.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == STS_DONE) || (rsp.status == STS_RANGE) ||
			(rsp.status == STS_FULL))
		else $error("undefined status code");

	// A failed command reads nothing.
	a_fail_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != STS_DONE) |-> rsp.read_value == NEG_ONE)
		else $error("failed command returned a read value");

	// A refused insert reports a full store.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == STS_FULL) |-> rsp.entry_count == CNT_OUT_W'(CAPACITY))
		else $error("full status with an entry count below capacity");

endmodule

bind indexed_list_store ils_chk #(
	.CAPACITY (CAPACITY)
) u_ils_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.cmd       (cmd),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

@@ tb/testbench.sv @@
// Self-checking testbench for the indexed list store: directed table, then random command words.
module testbench;
	import ils_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP          = CAPACITY_DEF;
	localparam int DIR_ROWS     = 25;
	localparam int RANDOM_WORDS = 1300;
	localparam int MAX_WAIT     = 16;
	localparam int LONG_HOLD    = 300;
	localparam int TAIL_CYCLES  = 2 * (4 + CAP);
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int SHOW_LIMIT   = 10;

	// Opcodes the block does not use.
	localparam logic [OPC_W-1:0] OP_RSV5 = 3'd5;
	localparam logic [OPC_W-1:0] OP_RSV6 = 3'd6;
	localparam logic [OPC_W-1:0] OP_RSV7 = 3'd7;

	// Drift of the random command mix.
	localparam int DRIFT_MIXED = 0;
	localparam int DRIFT_FILL  = 1;
	localparam int DRIFT_DRAIN = 2;

	typedef struct {
		cmd_t word;
		bit   fixed;
		rsp_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	// Mirror of the list contents and count.
	logic signed [DATA_W-1:0] list_mem [CAP];
	int held;

	rsp_t pending_rsp [$];
	dir_row_t dir_tab [DIR_ROWS];

	int  cycle_cnt = 0;
	int  mismatches = 0;
	int  words_sent = 0;
	int  rsp_checked = 0;
	int  full_refusals = 0;
	int  range_hits = 0;
	int  peak_held = 0;
	int  long_holds = 0;
	bit  in_burst = 1'b0;
	bit  long_hold_req = 1'b0;

	indexed_list_store #(.CAPACITY(CAP)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	// Idle cycles before the next word; none during a burst stretch.
	function automatic int draw_wait();
		if (in_burst) begin
			return 0;
		end
		return $urandom_range(0, MAX_WAIT);
	endfunction

	// Place a value at position p and move the later entries up.
	function automatic void list_insert(int p, logic signed [DATA_W-1:0] v);
		int i;
		for (i = held; i > p; i--) begin
			list_mem[i] = list_mem[i-1];
		end
		list_mem[p] = v;
		held++;
		if (held > peak_held) begin
			peak_held = held;
		end
	endfunction

	// Apply one command to the mirror and return the response it should give.
	function automatic rsp_t list_apply(cmd_t c);
		rsp_t r;
		int i;
		int p;
		p = int'(c.position);
		r.read_value = NEG_ONE;
		r.status     = STS_DONE;
		case (c.opcode)
			OP_READ: begin
				if (p < held) begin
					r.read_value = list_mem[p];
				end else begin
					r.status = STS_RANGE;
				end
			end
			OP_HEAD: begin
				if (held >= CAP) begin
					r.status = STS_FULL;
				end else begin
					list_insert(0, c.value);
				end
			end
			OP_TAIL: begin
				if (held >= CAP) begin
					r.status = STS_FULL;
				end else begin
					list_insert(held, c.value);
				end
			end
			OP_AT: begin
				// Range is checked before room.
				if (p > held) begin
					r.status = STS_RANGE;
				end else if (held >= CAP) begin
					r.status = STS_FULL;
				end else begin
					list_insert(p, c.value);
				end
			end
			OP_DEL: begin
				if (p >= held) begin
					r.status = STS_RANGE;
				end else begin
					for (i = p; i + 1 < held; i++) begin
						list_mem[i] = list_mem[i+1];
					end
					held--;
				end
			end
			default: begin
			end
		endcase
		if (r.status == STS_FULL) begin
			full_refusals++;
		end
		if (r.status == STS_RANGE) begin
			range_hits++;
		end
		r.entry_count = CNT_OUT_W'(held);
		return r;
	endfunction

	// Random command word; the drift tilts the mix toward filling or draining.
	function automatic cmd_t next_word(int drift);
		cmd_t c;
		int roll;
		int ins_pct;
		int del_pct;
		int pick;
		case (drift)
			DRIFT_MIXED: begin
				ins_pct = 35;
				del_pct = 30;
			end
			DRIFT_FILL: begin
				ins_pct = 65;
				del_pct = 15;
			end
			DRIFT_DRAIN: begin
				ins_pct = 20;
				del_pct = 60;
			end
			default: begin
				ins_pct = 35;
				del_pct = 30;
			end
		endcase
		roll = $urandom_range(0, 99);
		pick = $urandom_range(0, 2);
		if (roll < 5) begin
			c.opcode = (pick == 0) ? OP_RSV5 : (pick == 1) ? OP_RSV6 : OP_RSV7;
		end else if (roll < 5 + ins_pct) begin
			c.opcode = (pick == 0) ? OP_HEAD : (pick == 1) ? OP_TAIL : OP_AT;
		end else if (roll < 5 + ins_pct + del_pct) begin
			c.opcode = OP_DEL;
		end else begin
			c.opcode = OP_READ;
		end
		c.value = $urandom;
		if ($urandom_range(0, 15) == 0) begin
			c.value = ($urandom_range(0, 1) == 1) ? 32'sh7fffffff : 32'sh80000000;
		end
		// Mostly positions that land inside the list, some anywhere in the field.
		if ($urandom_range(0, 4) == 0) begin
			c.position = POS_W'($urandom_range(0, 127));
		end else if (c.opcode == OP_AT) begin
			c.position = POS_W'($urandom_range(0, held));
		end else if (held > 0) begin
			c.position = POS_W'($urandom_range(0, held - 1));
		end else begin
			c.position = '0;
		end
		return c;
	endfunction

	function automatic dir_row_t row(logic [OPC_W-1:0] op, int pos, logic signed [DATA_W-1:0] v,
			bit fixed, logic signed [DATA_W-1:0] rv, logic [STS_W-1:0] st, int cnt);
		dir_row_t d;
		d.word.opcode        = op;
		d.word.position      = POS_W'(pos);
		d.word.value         = v;
		d.fixed              = fixed;
		d.want.read_value    = rv;
		d.want.status        = st;
		d.want.entry_count   = CNT_OUT_W'(cnt);
		return d;
	endfunction

	// Offer one word, wait for it to be taken, and queue its expected response.
	task automatic send_word(input cmd_t c, input bit fixed, input rsp_t want);
		int gap;
		rsp_t pred;
		gap = draw_wait();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(posedge clk); while (!(cmd_valid && !cmd_stall));
		pred = list_apply(c);
		pending_rsp.push_back(fixed ? want : pred);
		words_sent++;
	endtask

	// Compare an accepted response with the oldest expected one.
	task automatic check_rsp(input rsp_t got);
		rsp_t want;
		if (pending_rsp.size() == 0) begin
			mismatches++;
			if (mismatches <= SHOW_LIMIT) begin
				$display("unexpected response: value %0d status %0d count %0d",
					got.read_value, got.status, got.entry_count);
			end
		end else begin
			want = pending_rsp.pop_front();
			if (got.read_value !== want.read_value || got.status !== want.status ||
					got.entry_count !== want.entry_count) begin
				mismatches++;
				if (mismatches <= SHOW_LIMIT) begin
					$display("response %0d: expected value %0d status %0d count %0d,",
						rsp_checked, want.read_value, want.status, want.entry_count,
						" got value %0d status %0d count %0d",
						got.read_value, got.status, got.entry_count);
				end
			end
		end
		rsp_checked++;
	endtask

	// Inputs known from time zero, reset held low at the start and then released.
	initial begin
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '0;
		rsp_stall = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Receiver: checks responses and stalls at random, with one long hold-off.
	initial begin : receiver
		int hold_left;
		wait (arst_n === 1'b1);
		hold_left = draw_wait();
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				check_rsp(rsp);
				hold_left = draw_wait();
			end
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD;
				long_holds++;
			end
			rsp_stall <= (hold_left > 0);
			if (hold_left > 0) begin
				hold_left--;
			end
		end
	end

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("timeout after %0d cycles with %0d responses outstanding",
			cycle_cnt, pending_rsp.size());
		$display("*** FAILED ***");
		$finish;
	end

	// Stimulus: directed table, then random words, then the drain and verdict.
	initial begin : stimulus
		int n;
		int drift;
		rsp_t none;
		none = '0;
		held = 0;
		dir_tab = '{
			// Empty store right after reset.
			row(OP_READ, 0, 32'sd0, 1, NEG_ONE, STS_RANGE, 0),
			row(OP_DEL, 0, 32'sd0, 1, NEG_ONE, STS_RANGE, 0),
			row(OP_AT, 1, 32'sd5, 1, NEG_ONE, STS_RANGE, 0),
			row(OP_RSV5, 0, 32'sd0, 1, NEG_ONE, STS_DONE, 0),
			// Value extremes at both ends.
			row(OP_HEAD, 0, 32'sh7fffffff, 1, NEG_ONE, STS_DONE, 1),
			row(OP_TAIL, 127, 32'sh80000000, 1, NEG_ONE, STS_DONE, 2),
			row(OP_READ, 0, 32'sd0, 1, 32'sh7fffffff, STS_DONE, 2),
			row(OP_READ, 1, 32'sd0, 1, 32'sh80000000, STS_DONE, 2),
			row(OP_AT, 1, 32'sd0, 0, NEG_ONE, STS_DONE, 0),
			row(OP_AT, 3, -32'sd1, 0, NEG_ONE, STS_DONE, 0),
			// Positions past the count.
			row(OP_AT, 5, 32'sd9, 1, NEG_ONE, STS_RANGE, 4),
			row(OP_READ, 127, 32'sd0, 1, NEG_ONE, STS_RANGE, 4),
			row(OP_READ, 4, 32'sd0, 1, NEG_ONE, STS_RANGE, 4),
			row(OP_READ, 3, 32'sd0, 0, NEG_ONE, STS_DONE, 0),
			row(OP_HEAD, 0, 32'sh55555555, 0, NEG_ONE, STS_DONE, 0),
			row(OP_TAIL, 0, 32'shaaaaaaaa, 0, NEG_ONE, STS_DONE, 0),
			row(OP_AT, 0, 32'sd1, 0, NEG_ONE, STS_DONE, 0),
			row(OP_DEL, 127, 32'sd0, 1, NEG_ONE, STS_RANGE, 7),
			// Delete the last and the first entry.
			row(OP_DEL, 6, 32'sd0, 0, NEG_ONE, STS_DONE, 0),
			row(OP_DEL, 0, 32'sd0, 0, NEG_ONE, STS_DONE, 0),
			row(OP_RSV6, 127, -32'sd1, 0, NEG_ONE, STS_DONE, 0),
			row(OP_RSV7, 0, 32'sd0, 0, NEG_ONE, STS_DONE, 0),
			row(OP_READ, 2, 32'sd0, 0, NEG_ONE, STS_DONE, 0),
			row(OP_DEL, 0, 32'sd0, 0, NEG_ONE, STS_DONE, 0),
			row(OP_READ, 0, 32'sd0, 0, NEG_ONE, STS_DONE, 0)
		};
		wait (arst_n === 1'b1);
		@(posedge clk);

		for (n = 0; n < DIR_ROWS; n++) begin
			send_word(dir_tab[n].word, dir_tab[n].fixed, dir_tab[n].want);
		end

		// Random words in stretches that fill, drain or mix the store.
		for (n = 0; n < RANDOM_WORDS; n++) begin
			drift = (n / 150) % 3;
			in_burst = ((n / 90) % 5 == 4);
			if (n == 300) begin
				long_hold_req = 1'b1;
			end
			if (n == 650) begin
				// Sender pause until every response is back.
				cmd_valid <= 1'b0;
				do @(posedge clk); while (pending_rsp.size() != 0);
			end
			send_word(next_word(drift), 1'b0, none);
		end
		in_burst = 1'b0;
		cmd_valid <= 1'b0;

		do @(posedge clk); while (pending_rsp.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d command words, %0d responses checked, %0d long hold-off(s).",
			words_sent, rsp_checked, long_holds);
		$display("Store peaked at %0d of %0d entries; %0d full refusals, %0d out-of-range.",
			peak_held, CAP, full_refusals, range_hits);
		if (mismatches == 0 && pending_rsp.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
